@@ rtl/cpio_pkg.sv @@
package cpio_pkg;

    // header geometry of an odc header
    localparam int unsigned HDR_LEN = 76;
    localparam int unsigned POS_W   = 7;
    localparam int unsigned NAME_W  = 18;
    localparam int unsigned SIZE_W  = 33;

    localparam logic [POS_W-1:0] POS_MODE_FIRST = POS_W'(18);
    localparam logic [POS_W-1:0] POS_MODE_END   = POS_W'(24);
    localparam logic [POS_W-1:0] POS_NAME_FIRST = POS_W'(59);
    localparam logic [POS_W-1:0] POS_SIZE_FIRST = POS_W'(65);
    localparam logic [POS_W-1:0] POS_HDR_LAST   = POS_W'(HDR_LEN - 1);

    // parse phases
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_NAME    = 3'd1;
    localparam logic [2:0] PH_LINK    = 3'd2;
    localparam logic [2:0] PH_CONTENT = 3'd3;
    localparam logic [2:0] PH_END     = 3'd4;
    localparam logic [2:0] PH_HALT    = 3'd5;

    // byte classes
    localparam logic [2:0] CLS_HEADER  = 3'd0;
    localparam logic [2:0] CLS_NAME    = 3'd1;
    localparam logic [2:0] CLS_LINK    = 3'd2;
    localparam logic [2:0] CLS_CONTENT = 3'd3;
    localparam logic [2:0] CLS_IGNORED = 3'd4;

    // entry kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_REG  = 2'd1;
    localparam logic [1:0] KIND_DIR  = 2'd2;
    localparam logic [1:0] KIND_LNK  = 2'd3;

    // octal field decoder states
    localparam logic [1:0] OCT_PAD    = 2'd0;
    localparam logic [1:0] OCT_DIGITS = 2'd1;
    localparam logic [1:0] OCT_STOP   = 2'd2;

    // mode type nibble (mode bits 15:12)
    localparam logic [3:0] MT_DIR  = 4'b0100;
    localparam logic [3:0] MT_REG  = 4'b1000;
    localparam logic [3:0] MT_CTG  = 4'b1001;
    localparam logic [3:0] MT_LNK  = 4'b1010;

    localparam logic [SIZE_W-1:0] TRAILER_LEN = SIZE_W'(10);

    typedef struct packed {
        logic [2:0]        phase;
        logic [SIZE_W-1:0] remaining;
        logic              done;
        logic              ended;
        logic              bad;
    } finish_t;

    function automatic logic [1:0] kind_of(input logic [NAME_W-1:0] mode);
        logic [1:0] k;
        k = KIND_NONE;
        if (mode[15:12] == MT_DIR) k = KIND_DIR;
        else if (mode[15:12] == MT_LNK) k = KIND_LNK;
        else if (mode[15:12] == MT_REG || mode[15:12] == MT_CTG) k = KIND_REG;
        return k;
    endfunction

    function automatic logic [7:0] trailer_char(input logic [3:0] i);
        logic [7:0] c;
        unique case (i)
            4'd0:    c = 8'h54; // T
            4'd1:    c = 8'h52; // R
            4'd2:    c = 8'h41; // A
            4'd3:    c = 8'h49; // I
            4'd4:    c = 8'h4C; // L
            4'd5:    c = 8'h45; // E
            4'd6:    c = 8'h52; // R
            default: c = 8'h21; // !
        endcase
        return c;
    endfunction

    // what follows a complete name
    function automatic finish_t finish_name(input logic              trailer_ok,
                                            input logic [NAME_W-1:0] name_len,
                                            input logic [1:0]        kind,
                                            input logic [SIZE_W-1:0] content_size,
                                            input logic [SIZE_W-1:0] remaining);
        finish_t f;
        f.phase     = PH_HEADER;
        f.remaining = remaining;
        f.done      = 1'b0;
        f.ended     = 1'b0;
        f.bad       = 1'b0;
        if (trailer_ok && (SIZE_W'(name_len) >= TRAILER_LEN)) begin
            f.phase = PH_END;
            f.ended = 1'b1;
        end else begin
            unique case (kind)
                KIND_REG, KIND_LNK: begin
                    f.remaining = content_size;
                    if (content_size == '0) begin
                        f.phase = PH_HEADER;
                        f.done  = 1'b1;
                    end else begin
                        f.phase = (kind == KIND_REG) ? PH_CONTENT : PH_LINK;
                    end
                end
                KIND_DIR: begin
                    f.phase = PH_HEADER;
                    f.done  = 1'b1;
                end
                default: begin
                    f.phase = PH_HALT;
                    f.bad   = 1'b1;
                end
            endcase
        end
        return f;
    endfunction

endpackage

@@ rtl/cpio_odc_archive_deframer_unit.sv @@
// cpio odc archive deframer
// s_* channel: one archive byte per word in s_tdata[7:0].
// m_* channel: one result word per input word. m_tuser carries the byte
// class (header, name, link target, content, ignored), m_tlast marks the
// last byte of a header, name, link or content section, and m_tdata carries
// the byte, the entry type, the parsed name and file sizes and the
// entry-done, archive-end and bad-type flags.
// The result of an accepted word is registered and shown from the next
// cycle on. Throughput is one word per cycle while the receiver takes
// results; the parse state and the result register are updated by one
// pass of logic per word.
// A new word is taken whenever the result register is empty or being
// drained; when the receiver stalls, s_tready drops and the held result
// stays unchanged.
// After reset the block expects a header at the first byte. After the
// trailer name, or after an entry of unknown type, every byte is labeled
// ignored until the next reset.
module cpio_odc_archive_deframer_unit
    import cpio_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] archive_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [7:0] data_byte, [9:8] entry_type,
                                   // [27:10] name_length, [60:28] content_length,
                                   // [61] entry_done, [62] archive_end, [63] bad_type
    output logic [7:0]  m_tuser,   // [2:0] byte_class
    output logic        m_tlast    // section_last
);

    // parse state
    logic [2:0]        phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [1:0]        oct_reg, oct_next;
    logic [NAME_W-1:0] mode_reg, mode_next;
    logic [NAME_W-1:0] nsize_reg, nsize_next;
    logic [SIZE_W-1:0] csize_reg, csize_next;
    logic [SIZE_W-1:0] remain_reg, remain_next;
    logic              trail_reg, trail_next;
    logic [1:0]        kind_reg, kind_next;

    // result register
    logic              out_valid_reg;
    logic [2:0]        out_cls_reg, cls;
    logic [7:0]        out_byte_reg;
    logic [1:0]        out_kind_reg;
    logic [NAME_W-1:0] out_nsize_reg;
    logic [SIZE_W-1:0] out_csize_reg;
    logic              out_last_reg, last;
    logic              out_done_reg, done;
    logic              out_end_reg, ended;
    logic              out_bad_reg, bad;

    logic              accept;
    logic              in_mode_f, in_name_f, in_size_f, field_first;
    logic [SIZE_W-1:0] dec_acc_in, dec_acc_out;
    logic [1:0]        dec_oct_in, dec_oct_out;
    logic [SIZE_W-1:0] name_idx;
    logic              trail_now;
    finish_t           fin;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // header field windows
    assign in_mode_f   = (pos_reg >= POS_MODE_FIRST) && (pos_reg < POS_MODE_END);
    assign in_name_f   = (pos_reg >= POS_NAME_FIRST) && (pos_reg < POS_SIZE_FIRST);
    assign in_size_f   = (pos_reg >= POS_SIZE_FIRST) && (pos_reg <= POS_HDR_LAST);
    assign field_first = (pos_reg == POS_MODE_FIRST) || (pos_reg == POS_NAME_FIRST)
                         || (pos_reg == POS_SIZE_FIRST);

    // one shared octal decoder, fed by whichever field is open
    always_comb begin
        dec_acc_in = csize_reg;
        if (in_mode_f) dec_acc_in = SIZE_W'(mode_reg);
        else if (in_name_f) dec_acc_in = SIZE_W'(nsize_reg);
        if (field_first) dec_acc_in = '0;
        dec_oct_in = field_first ? OCT_PAD : oct_reg;
    end

    cpio_octal_digit u_octal (
        .acc_in  (dec_acc_in),
        .oct_in  (dec_oct_in),
        .char_in (s_tdata),
        .acc_out (dec_acc_out),
        .oct_out (dec_oct_out)
    );

    assign name_idx = SIZE_W'(nsize_reg) - remain_reg;

    // trailer match after this name byte
    always_comb begin
        trail_now = trail_reg;
        if (name_idx < TRAILER_LEN) begin
            if (s_tdata != trailer_char(name_idx[3:0])) trail_now = 1'b0;
        end else if (name_idx == TRAILER_LEN) begin
            if (s_tdata != 8'h00) trail_now = 1'b0;
        end
    end

    // next state and result for one byte
    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        oct_next    = oct_reg;
        mode_next   = mode_reg;
        nsize_next  = nsize_reg;
        csize_next  = csize_reg;
        remain_next = remain_reg;
        trail_next  = trail_reg;
        kind_next   = kind_reg;
        cls   = CLS_IGNORED;
        last  = 1'b0;
        done  = 1'b0;
        ended = 1'b0;
        bad   = 1'b0;
        fin   = finish_name(trail_reg, nsize_reg, kind_reg, csize_reg, remain_reg);
        unique case (phase_reg)
            PH_HEADER: begin
                cls = CLS_HEADER;
                if (in_mode_f || in_name_f || in_size_f) oct_next = dec_oct_out;
                if (in_mode_f) mode_next = dec_acc_out[NAME_W-1:0];
                if (in_name_f) nsize_next = dec_acc_out[NAME_W-1:0];
                if (in_size_f) csize_next = dec_acc_out;
                if (pos_reg >= POS_HDR_LAST) begin
                    last        = 1'b1;
                    pos_next    = '0;
                    kind_next   = kind_of(mode_next);
                    trail_next  = 1'b1;
                    remain_next = SIZE_W'(nsize_next);
                    phase_next  = PH_NAME;
                    if (nsize_next == '0) begin
                        fin = finish_name(1'b1, nsize_next, kind_next, csize_next,
                                          SIZE_W'(nsize_next));
                        phase_next  = fin.phase;
                        remain_next = fin.remaining;
                        done        = fin.done;
                        ended       = fin.ended;
                        bad         = fin.bad;
                    end
                end else begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            PH_NAME: begin
                cls         = CLS_NAME;
                trail_next  = trail_now;
                remain_next = remain_reg - SIZE_W'(1);
                if (remain_reg == SIZE_W'(1)) begin
                    last = 1'b1;
                    fin  = finish_name(trail_now, nsize_reg, kind_reg, csize_reg,
                                       remain_reg - SIZE_W'(1));
                    phase_next  = fin.phase;
                    remain_next = fin.remaining;
                    done        = fin.done;
                    ended       = fin.ended;
                    bad         = fin.bad;
                end
            end
            PH_LINK, PH_CONTENT: begin
                cls         = (phase_reg == PH_LINK) ? CLS_LINK : CLS_CONTENT;
                remain_next = remain_reg - SIZE_W'(1);
                if (remain_reg == SIZE_W'(1)) begin
                    last       = 1'b1;
                    done       = 1'b1;
                    phase_next = PH_HEADER;
                end
            end
            PH_HALT: begin
                bad = 1'b1;
            end
            default: begin
                cls = CLS_IGNORED;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            oct_reg       <= OCT_PAD;
            mode_reg      <= '0;
            nsize_reg     <= '0;
            csize_reg     <= '0;
            remain_reg    <= '0;
            trail_reg     <= 1'b1;
            kind_reg      <= KIND_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                oct_reg    <= oct_next;
                mode_reg   <= mode_next;
                nsize_reg  <= nsize_next;
                csize_reg  <= csize_next;
                remain_reg <= remain_next;
                trail_reg  <= trail_next;
                kind_reg   <= kind_next;
            end
            if (accept) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_cls_reg   <= cls;
            out_byte_reg  <= s_tdata;
            out_kind_reg  <= kind_next;
            out_nsize_reg <= nsize_next;
            out_csize_reg <= csize_next;
            out_last_reg  <= last;
            out_done_reg  <= done;
            out_end_reg   <= ended;
            out_bad_reg   <= bad;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_bad_reg, out_end_reg, out_done_reg, out_csize_reg,
                       out_nsize_reg, out_kind_reg, out_byte_reg};
    assign m_tuser  = {5'b0, out_cls_reg};
    assign m_tlast  = out_last_reg;

    // once halted, parsing never resumes
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HALT |=> phase_reg == PH_HALT)
        else $error("halted parser resumed");

    // an entry cannot both complete and end the archive
    a_done_end_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_done_reg && out_end_reg))
        else $error("entry_done and archive_end together");

    // ignored bytes never close a section
    a_ignored_no_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_cls_reg == CLS_IGNORED |-> !out_last_reg)
        else $error("ignored byte flagged as section end");

    // bad type is never reported on link or content bytes
    a_bad_class: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_bad_reg |->
            (out_cls_reg != CLS_LINK && out_cls_reg != CLS_CONTENT))
        else $error("bad_type on link or content byte");

endmodule

@@ rtl/cpio_octal_digit.sv @@
module cpio_octal_digit
    import cpio_pkg::*;
(
    input  logic [SIZE_W-1:0] acc_in,
    input  logic [1:0]        oct_in,
    input  logic [7:0]        char_in,
    output logic [SIZE_W-1:0] acc_out,
    output logic [1:0]        oct_out
);

    logic is_pad;
    logic is_octal;

    assign is_pad   = (char_in == 8'h20) || (char_in == 8'h30);
    assign is_octal = (char_in >= 8'h30) && (char_in <= 8'h37);

    // skip leading pad, take digits, stop at first non-octal char
    always_comb begin
        acc_out = acc_in;
        oct_out = OCT_STOP;
        if (oct_in == OCT_PAD && is_pad) begin
            oct_out = OCT_PAD;
        end else if ((oct_in == OCT_PAD || oct_in == OCT_DIGITS) && is_octal) begin
            oct_out = OCT_DIGITS;
            acc_out = {acc_in[SIZE_W-4:0], char_in[2:0]};
        end
    end

endmodule
